[hw/rtl/sql_token_span_lexer_defines.svh]
// assertion macros shared by the lexer checker
`ifndef SQL_TOKEN_SPAN_LEXER_DEFINES_SVH
`define SQL_TOKEN_SPAN_LEXER_DEFINES_SVH

// checked only outside reset
`define STSL_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// checked in every cycle, reset included
`define STSL_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

[hw/rtl/stsl_pkg.sv]
// types, token kinds and character codes of the sql token span lexer
package stsl_pkg;

    typedef enum logic [5:0] {
        MODE_IDLE   = 6'b000001,
        MODE_WORD   = 6'b000010,
        MODE_MINUS  = 6'b000100,
        MODE_POINT  = 6'b001000,
        MODE_STRING = 6'b010000,
        MODE_CMP    = 6'b100000
    } lex_mode_t;

    localparam logic [3:0] KIND_END       = 4'd0;
    localparam logic [3:0] KIND_WORD      = 4'd1;
    localparam logic [3:0] KIND_NUMBER    = 4'd2;
    localparam logic [3:0] KIND_DECIMAL   = 4'd3;
    localparam logic [3:0] KIND_STRING    = 4'd4;
    localparam logic [3:0] KIND_STAR      = 4'd5;
    localparam logic [3:0] KIND_COMMA     = 4'd6;
    localparam logic [3:0] KIND_LPAREN    = 4'd7;
    localparam logic [3:0] KIND_RPAREN    = 4'd8;
    localparam logic [3:0] KIND_SEMICOLON = 4'd9;
    localparam logic [3:0] KIND_EQUALS    = 4'd10;
    localparam logic [3:0] KIND_CMP       = 4'd11;
    localparam logic [3:0] KIND_INVALID   = 4'd12;

    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_POINT  = 8'h2E;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_QUOTE  = 8'h27;

    localparam logic [15:0] LEN_MAX = 16'hFFFF;

    typedef struct packed {
        logic [15:0] length;
        logic [15:0] start;
        logic [3:0]  kind;
    } token_t;

    // kind of a byte that forms a token on its own
    function automatic logic [3:0] symbol_kind(input logic [7:0] c);
        logic [3:0] k;
        case (c)
            CH_STAR:   k = KIND_STAR;
            CH_COMMA:  k = KIND_COMMA;
            CH_LPAREN: k = KIND_LPAREN;
            CH_RPAREN: k = KIND_RPAREN;
            CH_SEMI:   k = KIND_SEMICOLON;
            CH_EQ:     k = KIND_EQUALS;
            default:   k = KIND_INVALID;
        endcase
        return k;
    endfunction

    function automatic logic [15:0] sat_add(input logic [15:0] a, input logic [1:0] b);
        logic [16:0] s;
        s = {1'b0, a} + 17'(b);
        return s[16] ? LEN_MAX : s[15:0];
    endfunction

endpackage

[hw/rtl/sql_token_span_lexer.sv]
// sql token span lexer: byte stream in, token spans out
//
// Takes one byte of query text per item (s_tlast marks the end of the text) and
// returns token spans of kind, start offset and length; m_tlast flags the last
// token caused by an input item, and a byte that only extends a token returns
// nothing. The lexer state is updated in the cycle an item is accepted and the
// tokens it produces (at most three) land in a small result register that drains
// one token per cycle while m_tready is high. Plain text streams at one byte per
// clock while the output is not stalled; a byte that yields several tokens holds
// s_tready low until the last of them is taken from the result register. Offsets
// count bytes since the last end item, wrap at 2^POS_BITS and are reported as
// their low 16 bits; lengths saturate at 65535.
module sql_token_span_lexer #(
    parameter int POS_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_code
    input  logic        s_tlast,   // end_of_text
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [3:0] token_kind, [19:4] span_start,
                                   // [35:20] span_length, [39:36] zero
    output logic        m_tlast    // last_of_run
);

    localparam int WIDE_BITS = (POS_BITS > 16) ? POS_BITS : 16;

    function automatic logic [15:0] span16(input logic [POS_BITS-1:0] p);
        logic [WIDE_BITS-1:0] w;
        w = WIDE_BITS'(p);
        return w[15:0];
    endfunction

    stsl_pkg::lex_mode_t   mode_reg, mode_next;
    logic [POS_BITS-1:0]   pos_reg, pos_next;
    logic [POS_BITS-1:0]   tstart_reg, tstart_next;
    logic [15:0]           len_reg, len_next;
    logic                  letter_reg, letter_next;
    logic                  point_reg, point_next;

    stsl_pkg::token_t      res_reg [3];
    stsl_pkg::token_t      res_next [3];
    logic [1:0]            cnt_reg, cnt_next;
    logic [1:0]            idx_reg, idx_next;

    logic                  s_accept, m_take, last_take;
    logic [7:0]            c;
    logic                  is_alpha, is_digit, is_space;
    logic [POS_BITS-1:0]   prev_pos;
    logic [3:0]            word_kind;
    logic                  run_idle;
    logic                  slot_vld [4];
    stsl_pkg::token_t      slot_tok [4];
    logic [1:0]            n_res;

    assign c        = s_tdata;
    assign is_alpha = (c inside {[8'h41:8'h5A], [8'h61:8'h7A]});
    assign is_digit = (c inside {[8'h30:8'h39]});
    assign is_space = (c inside {8'h20, [8'h09:8'h0D]});
    assign prev_pos = pos_reg - POS_BITS'(1);
    assign word_kind = letter_reg ? stsl_pkg::KIND_WORD :
                       (point_reg ? stsl_pkg::KIND_DECIMAL : stsl_pkg::KIND_NUMBER);

    assign m_tvalid  = (idx_reg != cnt_reg);
    assign m_tlast   = ((idx_reg + 2'd1) == cnt_reg);
    assign m_take    = m_tvalid && m_tready;
    assign last_take = m_take && m_tlast;
    assign s_tready  = !m_tvalid || last_take;
    assign s_accept  = s_tvalid && s_tready;
    assign m_tdata   = {4'b0000, res_reg[idx_reg]};

    // lexer step: slot 0 closes the pending token, slot 1 a dangling point,
    // slot 2 a symbol started by this byte, slot 3 the end token
    always_comb begin
        mode_next   = mode_reg;
        pos_next    = pos_reg;
        tstart_next = tstart_reg;
        len_next    = len_reg;
        letter_next = letter_reg;
        point_next  = point_reg;
        run_idle    = 1'b0;
        for (int i = 0; i < 4; i++) begin
            slot_vld[i] = 1'b0;
        end
        slot_tok[0] = '{length: len_reg, start: span16(tstart_reg), kind: word_kind};
        slot_tok[1] = '{length: 16'd1, start: span16(prev_pos),
                        kind: stsl_pkg::KIND_INVALID};
        slot_tok[2] = '{length: 16'd1, start: span16(pos_reg),
                        kind: stsl_pkg::symbol_kind(c)};
        slot_tok[3] = '{length: 16'd0, start: span16(pos_reg),
                        kind: stsl_pkg::KIND_END};

        if (s_tlast) begin
            case (mode_reg)
                stsl_pkg::MODE_WORD: begin
                    slot_vld[0] = 1'b1;
                end
                stsl_pkg::MODE_POINT: begin
                    slot_vld[0] = 1'b1;
                    slot_vld[1] = 1'b1;
                end
                stsl_pkg::MODE_MINUS: begin
                    slot_vld[0] = 1'b1;
                    slot_tok[0] = slot_tok[1];
                end
                stsl_pkg::MODE_STRING: begin
                    slot_vld[0]      = 1'b1;
                    slot_tok[0].kind = stsl_pkg::KIND_STRING;
                end
                stsl_pkg::MODE_CMP: begin
                    slot_vld[0] = 1'b1;
                    slot_tok[0] = '{length: 16'd1, start: span16(prev_pos),
                                    kind: stsl_pkg::KIND_CMP};
                end
                default: ;
            endcase
            slot_vld[3] = 1'b1;
            pos_next    = '0;
            mode_next   = stsl_pkg::MODE_IDLE;
            letter_next = 1'b0;
            point_next  = 1'b0;
            len_next    = '0;
        end else begin
            pos_next = pos_reg + POS_BITS'(1);
            case (mode_reg)
                stsl_pkg::MODE_WORD: begin
                    if (is_alpha || is_digit || c == stsl_pkg::CH_UNDER) begin
                        len_next    = stsl_pkg::sat_add(len_reg, 2'd1);
                        letter_next = letter_reg | is_alpha;
                    end else if (c == stsl_pkg::CH_POINT && !letter_reg && !point_reg) begin
                        mode_next = stsl_pkg::MODE_POINT;
                    end else begin
                        slot_vld[0] = 1'b1;
                        run_idle    = 1'b1;
                    end
                end
                stsl_pkg::MODE_POINT: begin
                    if (is_digit) begin
                        point_next = 1'b1;
                        len_next   = stsl_pkg::sat_add(len_reg, 2'd2);
                        mode_next  = stsl_pkg::MODE_WORD;
                    end else begin
                        slot_vld[0] = 1'b1;
                        slot_vld[1] = 1'b1;
                        run_idle    = 1'b1;
                    end
                end
                stsl_pkg::MODE_MINUS: begin
                    if (is_digit) begin
                        mode_next   = stsl_pkg::MODE_WORD;
                        tstart_next = prev_pos;
                        len_next    = 16'd2;
                        letter_next = 1'b0;
                        point_next  = 1'b0;
                    end else begin
                        slot_vld[0] = 1'b1;
                        slot_tok[0] = slot_tok[1];
                        run_idle    = 1'b1;
                    end
                end
                stsl_pkg::MODE_STRING: begin
                    if (c == stsl_pkg::CH_QUOTE) begin
                        slot_vld[0]      = 1'b1;
                        slot_tok[0].kind = stsl_pkg::KIND_STRING;
                        mode_next        = stsl_pkg::MODE_IDLE;
                    end else begin
                        len_next = stsl_pkg::sat_add(len_reg, 2'd1);
                    end
                end
                stsl_pkg::MODE_CMP: begin
                    slot_vld[0] = 1'b1;
                    slot_tok[0] = '{length: 16'd1, start: span16(prev_pos),
                                    kind: stsl_pkg::KIND_CMP};
                    if (c == stsl_pkg::CH_EQ) begin
                        slot_tok[0].length = 16'd2;
                        mode_next          = stsl_pkg::MODE_IDLE;
                    end else begin
                        run_idle = 1'b1;
                    end
                end
                default: begin
                    run_idle = 1'b1;
                end
            endcase

            // a byte seen while idle, or one that ended the previous token, may start a new one
            if (run_idle) begin
                mode_next = stsl_pkg::MODE_IDLE;
                if (is_space) begin
                    mode_next = stsl_pkg::MODE_IDLE;
                end else if (is_alpha || is_digit) begin
                    mode_next   = stsl_pkg::MODE_WORD;
                    tstart_next = pos_reg;
                    len_next    = 16'd1;
                    letter_next = is_alpha;
                    point_next  = 1'b0;
                end else if (c == stsl_pkg::CH_MINUS) begin
                    mode_next = stsl_pkg::MODE_MINUS;
                end else if (c == stsl_pkg::CH_QUOTE) begin
                    mode_next   = stsl_pkg::MODE_STRING;
                    tstart_next = pos_reg + POS_BITS'(1);
                    len_next    = '0;
                end else if (c == stsl_pkg::CH_GT || c == stsl_pkg::CH_LT) begin
                    mode_next = stsl_pkg::MODE_CMP;
                end else begin
                    slot_vld[2] = 1'b1;
                end
            end
        end
    end

    // pack the valid slots into the result register in order
    always_comb begin
        n_res = 2'd0;
        for (int i = 0; i < 3; i++) begin
            res_next[i] = slot_tok[3];
        end
        for (int i = 0; i < 4; i++) begin
            if (slot_vld[i] && n_res != 2'd3) begin
                res_next[n_res] = slot_tok[i];
                n_res           = n_res + 2'd1;
            end
        end
    end

    always_comb begin
        cnt_next = cnt_reg;
        idx_next = idx_reg;
        if (s_accept) begin
            cnt_next = n_res;
            idx_next = 2'd0;
        end else if (last_take) begin
            cnt_next = 2'd0;
            idx_next = 2'd0;
        end else if (m_take) begin
            idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= stsl_pkg::MODE_IDLE;
            pos_reg    <= '0;
            tstart_reg <= '0;
            len_reg    <= '0;
            letter_reg <= 1'b0;
            point_reg  <= 1'b0;
            cnt_reg    <= 2'd0;
            idx_reg    <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
            idx_reg <= idx_next;
            if (s_accept) begin
                mode_reg   <= mode_next;
                pos_reg    <= pos_next;
                tstart_reg <= tstart_next;
                len_reg    <= len_next;
                letter_reg <= letter_next;
                point_reg  <= point_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            for (int i = 0; i < 3; i++) begin
                res_reg[i] <= res_next[i];
            end
        end
    end

endmodule

[hw/rtl/stsl_checker.sv]
// port checker for the sql token span lexer and its bind
`include "sql_token_span_lexer_defines.svh"

module stsl_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic        m_tlast
);

    `STSL_ASSERT_ALWAYS(a_reset_empty, !aresetn |=> !m_tvalid, "result left after reset")

    `STSL_ASSERT(a_hold_stalled,
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast),
        "stalled item changed")

    // an end token closes its run and spans nothing
    `STSL_ASSERT(a_end_token,
        m_tvalid && m_tdata[3:0] == stsl_pkg::KIND_END |-> m_tlast && m_tdata[35:20] == 16'd0,
        "malformed end token")

    // a new byte only enters once the previous run is drained
    `STSL_ASSERT(a_no_overrun,
        s_tvalid && s_tready |-> !m_tvalid || (m_tready && m_tlast),
        "item accepted over pending results")

    `STSL_ASSERT(a_kind_range,
        m_tvalid |-> m_tdata[3:0] <= stsl_pkg::KIND_INVALID && m_tdata[39:36] == 4'd0,
        "bad token kind")

endmodule

bind sql_token_span_lexer stsl_checker u_stsl_checker (.*);
